>>> design/p80_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p80_pkg: shared types and functions for the PRESENT-80 encryption core
// s-box, bit permutation, key schedule step and controller/datapath signals
// ----------------------------------------------------------------------------
package p80_pkg;

  localparam int BLOCK_W  = 64;
  localparam int KEY_W    = 80;
  localparam int KEYHI_W  = 16;
  localparam int ROUND_W  = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [ROUND_W-1:0] LAST_ROUND = 5'd31;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b1;

  localparam logic [3:0] SBOX [16] = '{
    4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
    4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };

  typedef struct packed {
    logic load;
    logic round;
    logic finish;
  } p80_cmd_t;

  typedef struct packed {
    logic last_round;
  } p80_stat_t;

  function automatic logic [BLOCK_W-1:0] sbox_layer(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] r;
    r = '0;
    for (int n = 0; n < 16; n++) begin
      r[4*n +: 4] = SBOX[s[4*n +: 4]];
    end
    return r;
  endfunction

  // bit k moves to 16k mod 63, bit 63 stays: that is {k[1:0], k[5:2]}
  function automatic logic [BLOCK_W-1:0] perm_layer(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] r;
    logic [5:0]         idx;
    r = '0;
    for (int k = 0; k < BLOCK_W; k++) begin
      idx = 6'(k);
      r[{idx[1:0], idx[5:2]}] = s[k];
    end
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] key_update(input logic [KEY_W-1:0] k,
                                                  input logic [ROUND_W-1:0] rc);
    logic [KEY_W-1:0] r;
    r = {k[18:0], k[79:19]};
    r[79:76] = SBOX[r[79:76]];
    r[19:15] = r[19:15] ^ rc;
    return r;
  endfunction

endpackage

>>> design/p80_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p80_ctrl: sequencer for the PRESENT-80 core
// idle, a round state for the 31 rounds, then a final whitening state that issues the result
// ----------------------------------------------------------------------------
module p80_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  p80_pkg::p80_stat_t stat,
  output p80_pkg::p80_cmd_t  cmd
);
  import p80_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_FINAL = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        if (stat.last_round) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

>>> design/p80_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p80_datapath: key registers, cipher state, key schedule and output register
// one full round per cycle
// ----------------------------------------------------------------------------
module p80_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [p80_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [p80_pkg::BLOCK_W-1:0]         cfg_wdata,
  input  logic [p80_pkg::BLOCK_W-1:0]         in_plaintext,
  input  p80_pkg::p80_cmd_t                   cmd,
  output p80_pkg::p80_stat_t                  stat,
  output logic                                out_valid,
  output logic [p80_pkg::BLOCK_W-1:0]         out_ciphertext
);
  import p80_pkg::*;

  logic [KEYHI_W-1:0] key_high_r;
  logic [BLOCK_W-1:0] key_low_r;
  logic [BLOCK_W-1:0] data_r;
  logic [KEY_W-1:0]   key_r;
  logic [ROUND_W-1:0] round_r;
  logic               out_valid_r;
  logic [BLOCK_W-1:0] out_data_r;
  logic [BLOCK_W-1:0] round_key;

  assign round_key = key_r[KEY_W-1 -: BLOCK_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_HIGH: key_high_r <= cfg_wdata[KEYHI_W-1:0];
        REG_KEY_LOW:  key_low_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
      if (cmd.load) begin
        round_r <= ROUND_W'(1);
      end else if (cmd.round) begin
        round_r <= round_r + ROUND_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      data_r <= in_plaintext;
      key_r  <= {key_high_r, key_low_r};
    end else if (cmd.round) begin
      data_r <= perm_layer(sbox_layer(data_r ^ round_key));
      key_r  <= key_update(key_r, round_r);
    end
    if (cmd.finish) begin
      out_data_r <= data_r ^ round_key;
    end
  end

  assign stat.last_round = (round_r == LAST_ROUND);
  assign out_valid       = out_valid_r;
  assign out_ciphertext  = out_data_r;

endmodule

>>> design/present80_block_encrypt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// present80_block_encrypt: PRESENT-80 block encryption core
// A block is taken when start is high and busy is low. The round unit applies
// one full round per cycle, so the 31 rounds and a final whitening step put
// the ciphertext on out_ciphertext with a one-cycle out_valid strobe; busy
// drops as the strobe rises, so a new block can be started only once the
// strobe rises, not while a block is still running. The strobe cannot be held
// off: the result must be captured in its cycle. The 80-bit key is written
// through cfg_ (index 0: key bits 79..64, index 1: key bits 63..0); the user
// must write it only while busy is low, the block itself does not enforce it.
// ----------------------------------------------------------------------------
module present80_block_encrypt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [p80_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [p80_pkg::BLOCK_W-1:0]   cfg_wdata,
  input  logic                          start,
  output logic                          busy,
  input  logic [p80_pkg::BLOCK_W-1:0]   in_plaintext,
  output logic                          out_valid,
  output logic [p80_pkg::BLOCK_W-1:0]   out_ciphertext
);
  import p80_pkg::*;

  p80_cmd_t  cmd;
  p80_stat_t stat;

  p80_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  p80_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_plaintext   (in_plaintext),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_ciphertext (out_ciphertext)
  );

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("run ended without result strobe");

  a_strobe_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a run");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !busy && !cmd.round && !cmd.finish)
    else $error("load issued while running");

endmodule
